// ===== rtl/trapezoidal_motion_profile_defines.svh =====
// Assertion macros for the trapezoidal motion profile checker.
// Used by the bound checker only; needs a clock and reset named clock and reset.
`ifndef TRAPEZOIDAL_MOTION_PROFILE_DEFINES_SVH
`define TRAPEZOIDAL_MOTION_PROFILE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TMP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trapezoidal profile check failed");

// antecedent implies consequent in the next cycle
`define TMP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trapezoidal profile check failed");

`endif

// ===== rtl/trapmp_pkg.sv =====
// Shared types and constants of the trapezoidal motion profile.
// No dependencies.
`default_nettype none

package trapmp_pkg;

   localparam int DATA_W = 32;
   localparam int ACC_W  = 31;
   localparam int IDX_W  = 2;

   localparam logic [IDX_W-1:0] REG_MAX_VELOCITY = 2'd0;
   localparam logic [IDX_W-1:0] REG_MAX_ACCEL    = 2'd1;
   localparam logic [IDX_W-1:0] REG_DISTANCE     = 2'd2;

   localparam logic [1:0] PH_ACCEL = 2'd0;
   localparam logic [1:0] PH_COAST = 2'd1;
   localparam logic [1:0] PH_DECEL = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   typedef enum logic [1:0] {
      DOP_RAMP_DIST = 2'd0,
      DOP_RAMP_TIME = 2'd1,
      DOP_COAST     = 2'd2,
      DOP_TRI_Q     = 2'd3
   } div_op_type;

   typedef struct packed {
      logic       load_time;
      logic       vsq_en;
      logic       div_start;
      div_op_type div_op;
      logic       sqrt_start;
      logic       tri_sat;
      logic       plan_end;
      logic       query_en;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic trap;
      logic q_big;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/trapmp_div.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
// Uses no package.
`default_nettype none

module trapmp_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);

   logic [63:0] dq_ff, dq_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        ge;

   assign shifted = {rem_ff, dq_ff[63]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in  = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         dq_in   = {dq_ff[62:0], ge};
         rem_in  = ge ? diff[31:0] : shifted[31:0];
         cnt_in  = cnt_ff - 7'd1;
         done_in = (cnt_ff == 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

`default_nettype wire

// ===== rtl/trapmp_sqrt.sv =====
// Bitwise integer square root of a 64-bit value, one result bit per cycle.
// Uses no package.
`default_nettype none

module trapmp_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic [31:0]      root
);

   logic [63:0] x_ff, x_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      done_in = 1'b0;
      if (start) begin
         x_in   = radicand;
         res_in = '0;
         bit_in = 64'h4000_0000_0000_0000;
      end else if (bit_ff != '0) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         done_in = bit_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         bit_ff  <= bit_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

// ===== rtl/trapmp_dp.sv =====
// Datapath: configuration registers, plan registers, divider, square root and
// the query multiplier. Depends on trapmp_pkg, trapmp_div and trapmp_sqrt.
`default_nettype none

module trapmp_dp #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire trapmp_pkg::cmd_type                    cmd,
   output trapmp_pkg::status_type                      status,
   input  wire logic                                   csr_we,
   input  wire logic [trapmp_pkg::IDX_W-1:0]           csr_index,
   input  wire logic [trapmp_pkg::DATA_W-1:0]          csr_wdata,
   input  wire logic [trapmp_pkg::DATA_W-1:0]          req_query_time,
   output logic [trapmp_pkg::DATA_W-1:0]               rsp_velocity,
   output logic signed [trapmp_pkg::DATA_W-1:0]        rsp_acceleration,
   output logic [1:0]                                  rsp_phase
);

   localparam int PROD_W = trapmp_pkg::DATA_W + trapmp_pkg::ACC_W;

   logic [31:0] vmax_ff, amax_ff_w, dist_ff;
   logic [30:0] amax_ff;
   logic [31:0] time_ff;
   logic [63:0] vsq_ff, rd2_ff, q_ff;
   logic [31:0] ramp_ff, coast_ff, end_ff;
   logic [31:0] vel_ff, vel_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  ph_ff, ph_in;

   logic [31:0] v_eff;
   logic [30:0] a_eff;
   logic [63:0] div_dividend, div_quot, sqrt_rad;
   logic [31:0] div_divisor, root;
   logic        div_done, sqrt_done;
   logic [33:0] end_sum;
   logic [32:0] coast_end;
   logic [31:0] mul_op;
   logic [PROD_W-1:0] prod, prod_sh;
   logic [31:0] vel_sat;

   function automatic logic [31:0] sat32(input logic [63:0] x);
      return (x[63:32] != '0) ? 32'hFFFF_FFFF : x[31:0];
   endfunction

   assign amax_ff_w = {1'b0, amax_ff};
   assign v_eff = (vmax_ff == '0) ? 32'd1 : vmax_ff;
   assign a_eff = (amax_ff == '0) ? 31'd1 : amax_ff;

   // operand select for the shared divider
   always_comb begin
      unique case (cmd.div_op)
         trapmp_pkg::DOP_RAMP_DIST: begin
            div_dividend = vsq_ff;
            div_divisor  = {1'b0, a_eff};
         end
         trapmp_pkg::DOP_RAMP_TIME: begin
            div_dividend = {32'b0, v_eff} << FRAC_BITS;
            div_divisor  = {1'b0, a_eff};
         end
         trapmp_pkg::DOP_COAST: begin
            div_dividend = {32'b0, dist_ff - rd2_ff[31:0]} << FRAC_BITS;
            div_divisor  = v_eff;
         end
         default: begin
            div_dividend = {32'b0, dist_ff} << FRAC_BITS;
            div_divisor  = {1'b0, a_eff};
         end
      endcase
   end

   assign sqrt_rad = q_ff << FRAC_BITS;

   trapmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   trapmp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (root)
   );

   assign end_sum   = {1'b0, ramp_ff, 1'b0} + {2'b0, coast_ff};
   assign coast_end = {1'b0, ramp_ff} + {1'b0, coast_ff};

   assign status.div_done  = div_done;
   assign status.sqrt_done = sqrt_done;
   assign status.trap      = (rd2_ff[63:32] == '0) && (dist_ff >= rd2_ff[31:0]);
   assign status.q_big     = (q_ff >> (64 - FRAC_BITS)) != '0;

   // query: phase compare, one multiply, saturate
   assign mul_op  = (time_ff < ramp_ff) ? time_ff : end_ff - time_ff;
   assign prod    = {31'b0, mul_op} * {32'b0, a_eff};
   assign prod_sh = prod >> FRAC_BITS;
   assign vel_sat = (prod_sh[PROD_W-1:32] != '0) ? 32'hFFFF_FFFF : prod_sh[31:0];

   always_comb begin
      if (time_ff < ramp_ff) begin
         vel_in = vel_sat;
         acc_in = {1'b0, a_eff};
         ph_in  = trapmp_pkg::PH_ACCEL;
      end else if ({1'b0, time_ff} < coast_end) begin
         vel_in = v_eff;
         acc_in = '0;
         ph_in  = trapmp_pkg::PH_COAST;
      end else if (time_ff < end_ff) begin
         vel_in = vel_sat;
         acc_in = 32'd0 - {1'b0, a_eff};
         ph_in  = trapmp_pkg::PH_DECEL;
      end else begin
         vel_in = '0;
         acc_in = '0;
         ph_in  = trapmp_pkg::PH_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vmax_ff  <= 32'h0001_0000;
         amax_ff  <= 31'h0001_0000;
         dist_ff  <= '0;
         ramp_ff  <= '0;
         coast_ff <= '0;
         end_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               trapmp_pkg::REG_MAX_VELOCITY: vmax_ff <= csr_wdata;
               trapmp_pkg::REG_MAX_ACCEL:    amax_ff <= csr_wdata[30:0];
               trapmp_pkg::REG_DISTANCE:     dist_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (div_done) begin
            unique case (cmd.div_op)
               trapmp_pkg::DOP_RAMP_TIME: ramp_ff  <= sat32(div_quot);
               trapmp_pkg::DOP_COAST:     coast_ff <= sat32(div_quot);
               default: ;
            endcase
         end
         if (sqrt_done) begin
            ramp_ff  <= root;
            coast_ff <= '0;
         end
         if (cmd.tri_sat) begin
            ramp_ff  <= 32'hFFFF_FFFF;
            coast_ff <= '0;
         end
         if (cmd.plan_end) begin
            end_ff <= (end_sum[33:32] != '0) ? 32'hFFFF_FFFF : end_sum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_time) time_ff <= req_query_time;
      if (cmd.vsq_en) vsq_ff <= {32'b0, v_eff} * {32'b0, v_eff};
      if (div_done && cmd.div_op == trapmp_pkg::DOP_RAMP_DIST) rd2_ff <= div_quot;
      if (div_done && cmd.div_op == trapmp_pkg::DOP_TRI_Q) q_ff <= div_quot;
      if (cmd.query_en) begin
         vel_ff <= vel_in;
         acc_ff <= acc_in;
         ph_ff  <= ph_in;
      end
   end

   assign rsp_velocity     = vel_ff;
   assign rsp_acceleration = acc_ff;
   assign rsp_phase        = ph_ff | {2{amax_ff_w[31]}};

endmodule

`default_nettype wire

// ===== rtl/trapmp_ctrl.sv =====
// Controller: request/response handshake, plan sequencing and plan validity.
// Depends on trapmp_pkg.
`default_nettype none

module trapmp_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic                          csr_we,
   input  wire logic [trapmp_pkg::IDX_W-1:0]  csr_index,
   input  wire trapmp_pkg::status_type        status,
   output trapmp_pkg::cmd_type                cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_VSQ    = 10'b00_0000_0010,
      S_DRD    = 10'b00_0000_0100,
      S_BRANCH = 10'b00_0000_1000,
      S_DRAMP  = 10'b00_0001_0000,
      S_DCOAST = 10'b00_0010_0000,
      S_DQ     = 10'b00_0100_0000,
      S_SQRT   = 10'b00_1000_0000,
      S_FINISH = 10'b01_0000_0000,
      S_QUERY  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      plan_ok_ff, plan_ok_in;
   logic      issued_ff, issued_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free, cfg_hit;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cfg_hit   = csr_we && (csr_index == trapmp_pkg::REG_MAX_VELOCITY ||
                                 csr_index == trapmp_pkg::REG_MAX_ACCEL ||
                                 csr_index == trapmp_pkg::REG_DISTANCE);

   always_comb begin
      state_in     = state_ff;
      plan_ok_in   = plan_ok_ff && !cfg_hit;
      issued_in    = issued_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.div_op   = trapmp_pkg::DOP_RAMP_DIST;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_time = accept;
            if (accept) state_in = plan_ok_ff ? S_QUERY : S_VSQ;
         end
         S_VSQ: begin
            cmd.vsq_en = 1'b1;
            state_in   = S_DRD;
         end
         S_DRD, S_DRAMP, S_DCOAST, S_DQ: begin
            priority case (1'b1)
               state_ff == S_DRD:   cmd.div_op = trapmp_pkg::DOP_RAMP_DIST;
               state_ff == S_DRAMP: cmd.div_op = trapmp_pkg::DOP_RAMP_TIME;
               state_ff == S_DCOAST: cmd.div_op = trapmp_pkg::DOP_COAST;
               default:             cmd.div_op = trapmp_pkg::DOP_TRI_Q;
            endcase
            cmd.div_start = !issued_ff;
            issued_in     = 1'b1;
            if (status.div_done) begin
               issued_in = 1'b0;
               priority case (1'b1)
                  state_ff == S_DRD:   state_in = S_BRANCH;
                  state_ff == S_DRAMP: state_in = S_DCOAST;
                  state_ff == S_DCOAST: state_in = S_FINISH;
                  default:             state_in = S_SQRT;
               endcase
            end
         end
         S_BRANCH: begin
            state_in = status.trap ? S_DRAMP : S_DQ;
         end
         S_SQRT: begin
            if (status.q_big) begin
               cmd.tri_sat = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.sqrt_start = !issued_ff;
               issued_in      = 1'b1;
               if (status.sqrt_done) begin
                  issued_in = 1'b0;
                  state_in  = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            cmd.plan_end = 1'b1;
            plan_ok_in   = 1'b1;
            state_in     = S_QUERY;
         end
         S_QUERY: begin
            // hold until the output register can take the response
            if (out_free) begin
               cmd.query_en = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         plan_ok_ff   <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plan_ok_ff   <= plan_ok_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/trapezoidal_motion_profile.sv =====
// Trapezoidal velocity profile generator, top level.
// Depends on trapmp_pkg, trapmp_ctrl and trapmp_dp.
//
// Usage: write max_velocity (index 0), max_acceleration (1) and
// total_distance (2) on the csr_ port while no request is in flight. Each
// request carries an elapsed time; the response gives velocity, signed
// acceleration and phase at that time.
// With a valid plan the accepted request goes to S_QUERY, which registers
// the response once the output register is free; a new request is taken
// only back in S_IDLE. The first request after reset or after a write to
// index 0, 1 or 2 first plans the move: one squaring, then three 64-step
// divisions (trapezoid) or two divisions and a 32-step square root
// (triangle; none if the ramp saturates) on one shared restoring divider.
// Reset restores V = 1.0, A = 1.0, D = 0 and marks the plan stale.
// A stalled receiver holds the response in the output register; one more
// request is accepted meanwhile and waits until the register frees.
`default_nettype none

module trapezoidal_motion_profile #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [trapmp_pkg::DATA_W-1:0]         req_query_time,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [trapmp_pkg::DATA_W-1:0]              rsp_velocity,
   output logic signed [trapmp_pkg::DATA_W-1:0]       rsp_acceleration,
   output logic [1:0]                                 rsp_phase,
   input  wire logic                                  csr_we,
   input  wire logic [trapmp_pkg::IDX_W-1:0]          csr_index,
   input  wire logic [trapmp_pkg::DATA_W-1:0]         csr_wdata
);

   trapmp_pkg::cmd_type    cmd;
   trapmp_pkg::status_type status;

   trapmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .status    (status),
      .cmd       (cmd)
   );

   trapmp_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_query_time   (req_query_time),
      .rsp_velocity     (rsp_velocity),
      .rsp_acceleration (rsp_acceleration),
      .rsp_phase        (rsp_phase)
   );

endmodule

`default_nettype wire

// ===== rtl/trapmp_checker.sv =====
// Port-level checker for the trapezoidal motion profile, bound to the top.
// Depends on trapezoidal_motion_profile_defines.svh and trapmp_pkg.
`default_nettype none
`include "trapezoidal_motion_profile_defines.svh"

module trapmp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_velocity,
   input wire logic [31:0] rsp_acceleration,
   input wire logic [1:0]  rsp_phase
);

   `TMP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_velocity) && $stable(rsp_phase))
   `TMP_ASSERT_NOW(a_done_zero, rsp_valid && rsp_phase == trapmp_pkg::PH_DONE, rsp_velocity == '0 && rsp_acceleration == '0)
   `TMP_ASSERT_NOW(a_accel_pos, rsp_valid && rsp_phase == trapmp_pkg::PH_ACCEL, !rsp_acceleration[31] && rsp_acceleration != '0)
   `TMP_ASSERT_NOW(a_coast_flat, rsp_valid && rsp_phase == trapmp_pkg::PH_COAST, rsp_acceleration == '0 && rsp_velocity != '0)
   `TMP_ASSERT_NOW(a_decel_neg, rsp_valid && rsp_phase == trapmp_pkg::PH_DECEL, rsp_acceleration[31])

endmodule

bind trapezoidal_motion_profile trapmp_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_velocity     (rsp_velocity),
   .rsp_acceleration (rsp_acceleration),
   .rsp_phase        (rsp_phase)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the trapezoidal motion profile generator.
// Depends on trapmp_pkg and the trapezoidal_motion_profile RTL; predicts each
// response from its own copy of the plan and checks it field by field.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam logic [trapmp_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [31:0]        velocity;
      logic signed [31:0] acceleration;
      logic [1:0]         phase;
   } motion_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [trapmp_pkg::DATA_W-1:0] req_query_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [trapmp_pkg::DATA_W-1:0] rsp_velocity;
   logic signed [trapmp_pkg::DATA_W-1:0] rsp_acceleration;
   logic [1:0] rsp_phase;
   logic csr_we = 1'b0;
   logic [trapmp_pkg::IDX_W-1:0] csr_index = '0;
   logic [trapmp_pkg::DATA_W-1:0] csr_wdata = '0;

   trapezoidal_motion_profile #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_query_time(req_query_time),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_velocity(rsp_velocity),
      .rsp_acceleration(rsp_acceleration), .rsp_phase(rsp_phase),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the registers and the plan
   logic [31:0] peak_vel, peak_acc, move_dist;
   logic [31:0] ramp_t, coast_t, end_t;
   logic        plan_ok;

   motion_sample_type expected_motion[$];
   int  errors = 0;
   int  queries_sent = 0;
   int  responses_seen = 0;
   int  profiles_run = 0;
   int  cycles = 0;
   bit  idle_on = 1'b1;
   int  phase_hits[4] = '{0, 0, 0, 0};

   function automatic logic [31:0] sat32(logic [63:0] x);
      return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   task automatic plan_move();
      logic [63:0] v, a, d, both_ramps, q;
      v = (peak_vel == 0) ? 64'd1 : {32'd0, peak_vel};
      a = (peak_acc == 0) ? 64'd1 : {32'd0, peak_acc};
      d = {32'd0, move_dist};
      both_ramps = (v * v) / a;
      if (d >= both_ramps) begin
         ramp_t = sat32((v << FRAC) / a);
         coast_t = sat32(((d - both_ramps) << FRAC) / v);
      end else begin
         q = (d << FRAC) / a;
         if (q >= (64'd1 << (64 - FRAC))) ramp_t = 32'hFFFF_FFFF;
         else ramp_t = sat32(floor_sqrt(q << FRAC));
         coast_t = 0;
      end
      end_t = sat32(2 * {32'd0, ramp_t} + {32'd0, coast_t});
      plan_ok = 1'b1;
   endtask

   task automatic predict_motion(input logic [31:0] t, output motion_sample_type s);
      logic [63:0] a, coast_end;
      if (!plan_ok) plan_move();
      a = (peak_acc == 0) ? 64'd1 : {32'd0, peak_acc};
      coast_end = {32'd0, ramp_t} + {32'd0, coast_t};
      s.velocity = 0;
      s.acceleration = 0;
      s.phase = trapmp_pkg::PH_DONE;
      if ({32'd0, t} < {32'd0, ramp_t}) begin
         s.velocity = sat32(({32'd0, t} * a) >> FRAC);
         s.acceleration = a[31:0];
         s.phase = trapmp_pkg::PH_ACCEL;
      end else if ({32'd0, t} < coast_end) begin
         s.velocity = (peak_vel == 0) ? 32'd1 : peak_vel;
         s.phase = trapmp_pkg::PH_COAST;
      end else if (t < end_t) begin
         s.velocity = sat32(({32'd0, end_t} - {32'd0, t}) * a >> FRAC);
         s.acceleration = 32'd0 - a[31:0];
         s.phase = trapmp_pkg::PH_DECEL;
      end
   endtask

   // one request; valid is only lowered when an idle cycle is taken
   task automatic send_query(input logic [31:0] t);
      motion_sample_type s;
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_query_time <= t;
      do @(posedge clock); while (!req_ready);
      predict_motion(t, s);
      expected_motion.push_back(s);
      phase_hits[s.phase]++;
      queries_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [trapmp_pkg::IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      unique case (idx)
         trapmp_pkg::REG_MAX_VELOCITY: begin peak_vel = val; plan_ok = 1'b0; end
         trapmp_pkg::REG_MAX_ACCEL: begin peak_acc = {1'b0, val[30:0]}; plan_ok = 1'b0; end
         trapmp_pkg::REG_DISTANCE: begin move_dist = val; plan_ok = 1'b0; end
         default: ;
      endcase
   endtask

   task automatic set_move(input logic [31:0] v, input logic [31:0] a, input logic [31:0] d);
      drain();
      write_csr(trapmp_pkg::REG_MAX_VELOCITY, v);
      write_csr(trapmp_pkg::REG_MAX_ACCEL, a);
      write_csr(trapmp_pkg::REG_DISTANCE, d);
      profiles_run++;
   endtask

   // plan on the first request, then hit both sides of every boundary
   task automatic probe_boundaries();
      logic [31:0] ce;
      send_query(32'd0);
      ce = ramp_t + coast_t;
      send_query(ramp_t - 1);
      send_query(ramp_t);
      send_query(ce - 1);
      send_query(ce);
      send_query(end_t - 1);
      send_query(end_t);
      send_query(32'hFFFF_FFFF);
   endtask

   function automatic logic [31:0] pick_time();
      logic [31:0] ce;
      ce = ramp_t + coast_t;
      unique case ($urandom_range(9))
         0: return $urandom;
         1: return ramp_t + $urandom_range(2) - 1;
         2: return ce + $urandom_range(2) - 1;
         3: return end_t + $urandom_range(2) - 1;
         default: return (end_t == 0) ? $urandom_range(15)
                         : $urandom_range(end_t < 32'hFFFF_FFF0 ? end_t + 8 : end_t);
      endcase
   endfunction

   task automatic test_reset_state();
      // reset shadow: V = A = 1.0, D = 0, so everything is done
      send_query(32'd0);
      send_query(32'd1);
      send_query(32'hFFFF_FFFF);
      send_query(32'h5555_AAAA);
      profiles_run++;
   endtask

   task automatic test_directed_profiles();
      set_move(32'h0004_0000, 32'h0002_0000, 32'h0020_0000);   // trapezoid
      probe_boundaries();
      set_move(32'h0010_0000, 32'h0001_0000, 32'h0004_0000);   // triangle
      probe_boundaries();
      // zero velocity and acceleration act as one LSB
      set_move(32'd0, 32'd0, 32'h0000_0100);
      send_query(32'd0);
      send_query(32'h0000_8000);
      // very long triangle ramp saturates, and the top accel bit is dropped
      set_move(32'hFFFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF);
      probe_boundaries();
      set_move(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      probe_boundaries();
      // the unused index writes nothing and keeps the plan
      drain();
      write_csr(REG_UNUSED, 32'hFFFF_FFFF);
      send_query(32'd5);
   endtask

   task automatic test_random_profiles();
      int n;
      logic [31:0] v, a, d;
      for (int p = 0; p < 30; p++) begin
         idle_on = (p != 10);
         case ($urandom_range(3))
            0: begin v = $urandom; a = $urandom; d = $urandom; end
            1: begin
               v = $urandom_range(1, 255) << 12;
               a = $urandom_range(1, 255) << 12;
               d = $urandom_range(0, 32'h00FF_FFFF);
            end
            2: begin
               v = $urandom_range(1, 32'hFFFF);
               a = $urandom_range(1, 32'hFFFF);
               d = $urandom_range(0, 32'hFFFF);
            end
            default: begin
               v = $urandom_range(1, 64) << 16;
               a = $urandom_range(1, 64) << 16;
               d = $urandom_range(1, 2048) << 16;
            end
         endcase
         set_move(v, a, d);
         send_query($urandom_range(3));
         n = $urandom_range(45, 65);
         for (int i = 0; i < n; i++) send_query(pick_time());
      end
      idle_on = 1'b1;
   endtask

   always @(negedge clock)
      rsp_ready <= (idle_on && $urandom_range(99) < 35) ? 1'b0 : 1'b1;

   always @(posedge clock) begin
      motion_sample_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (expected_motion.size() == 0) begin
            errors++;
            $display("%0t: response with no request pending", $realtime);
         end else begin
            e = expected_motion.pop_front();
            if (rsp_velocity !== e.velocity || rsp_acceleration !== e.acceleration
                || rsp_phase !== e.phase) begin
               errors++;
               $display("%0t: mismatch exp vel %h acc %h ph %0d, got vel %h acc %h ph %0d",
                        $realtime, e.velocity, e.acceleration, e.phase,
                        rsp_velocity, rsp_acceleration, rsp_phase);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("trapezoidal_motion_profile regression: fail");
         $finish;
      end
   end

   initial begin
      peak_vel = 32'h0001_0000;
      peak_acc = 32'h0001_0000;
      move_dist = 0;
      ramp_t = 0;
      coast_t = 0;
      end_t = 0;
      plan_ok = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_profiles();
      test_random_profiles();
      drain();
      if (expected_motion.size() != 0) errors++;
      $display("ran %0d profiles, %0d requests, %0d responses, %0d errors",
               profiles_run, queries_sent, responses_seen, errors);
      $display("phases seen: accel %0d coast %0d decel %0d done %0d",
               phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3]);
      if (errors == 0) begin
         $display("trapezoidal_motion_profile regression: pass");
      end else begin
         $display("trapezoidal_motion_profile regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
